### hw/rtl/ske_pkg.sv
package ske_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned GAIN_BITS     = 16;
  localparam int unsigned GAIN_W        = GAIN_BITS + 1;
  localparam int unsigned REG_W         = 31;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned DIFF_W        = DATA_W + 1;
  localparam int unsigned PROD_W        = GAIN_W + DIFF_W;
  localparam int unsigned GROW_W        = 64;
  localparam int unsigned DIV_STEPS     = GAIN_W;
  localparam int unsigned CNT_W         = $clog2(DIV_STEPS);
  localparam int unsigned ADDR_W        = 4;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

  localparam logic [REG_W-1:0] MEAS_ERR_RST = 31'd65536;
  localparam logic [REG_W-1:0] INIT_ERR_RST = 31'd65536;
  localparam logic [REG_W-1:0] PNOISE_RST   = 31'd655;

  localparam logic [1:0] REG_MEAS_ERR = 2'd0;
  localparam logic [1:0] REG_INIT_ERR = 2'd1;
  localparam logic [1:0] REG_PNOISE   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEN,
    ST_MAG,
    ST_DIV,
    ST_GAIN,
    ST_MEST,
    ST_EST,
    ST_MKEEP,
    ST_MGLO,
    ST_MGHI,
    ST_GACC,
    ST_SUM
  } state_t;

endpackage

### hw/rtl/scalar_kalman_estimator.sv
// Scalar Kalman estimator, Q16.16 fixed point, one sample word in, one result word out.
// A sample word is taken only in idle, once the last result commits; a result not yet
//   taken by result_ready stalls that commit. Work runs through the 17-step restoring
//   divider for the gain and four passes through the one shared 17x33 multiplier.
// Reset (rst, synchronous, active high): control and configuration registers take reset
//   values; last estimate and gain clear; estimation error loads its initial value.
module scalar_kalman_estimator #(
  parameter int unsigned FRAC_BITS = ske_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // sample channel
  input  logic                              sample_valid,
  output logic                              sample_ready,
  input  logic signed [ske_pkg::DATA_W-1:0] sample,
  // result channel
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic signed [ske_pkg::DATA_W-1:0] estimate,
  output logic        [ske_pkg::GAIN_W-1:0] gain,
  output logic        [ske_pkg::REG_W-1:0]  error_now,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic        [ske_pkg::ADDR_W-1:0] paddr,
  input  logic        [ske_pkg::DATA_W-1:0] pwdata,
  output logic        [ske_pkg::DATA_W-1:0] prdata,
  output logic                              pready
);

  ske_pkg::state_t state, state_next;

  // configuration registers
  logic [ske_pkg::REG_W-1:0] meas_err;
  logic [ske_pkg::REG_W-1:0] init_err;
  logic [ske_pkg::REG_W-1:0] pnoise;

  // filter state; these also drive the result word
  logic signed [ske_pkg::DATA_W-1:0] last_estimate;
  logic        [ske_pkg::REG_W-1:0]  estimate_error;
  logic        [ske_pkg::GAIN_W-1:0] last_gain;

  // working registers of the sequencer
  logic signed [ske_pkg::DATA_W-1:0] samp;
  logic        [ske_pkg::DATA_W-1:0] den;
  logic signed [ske_pkg::DIFF_W-1:0] diff;
  logic        [ske_pkg::DIFF_W-1:0] mag;
  logic                              neg;
  logic        [ske_pkg::DATA_W-1:0] rem;
  logic        [ske_pkg::GAIN_W-1:0] quot;
  logic        [ske_pkg::CNT_W-1:0]  cnt;
  logic        [ske_pkg::GAIN_W-1:0] gain_w;
  logic        [ske_pkg::GAIN_W-1:0] ngain;
  logic        [ske_pkg::DIFF_W-1:0] change;
  logic signed [ske_pkg::DATA_W-1:0] est_new;
  logic        [ske_pkg::REG_W-1:0]  keep;
  logic        [47:0]                glo;
  logic        [ske_pkg::GROW_W-1:0] gtotal;
  logic        [ske_pkg::PROD_W-1:0] prod;

  // shared multiplier operands
  logic [ske_pkg::GAIN_W-1:0] mul_a;
  logic [ske_pkg::DIFF_W-1:0] mul_b;

  // combinational helpers
  logic                              cfg_wr;
  logic                              commit;
  logic                              div_last;
  logic [ske_pkg::DIFF_W-1:0]        rem_shift;
  logic [ske_pkg::DIFF_W-1:0]        rem_sub;
  logic                              rem_ge;
  logic [ske_pkg::DATA_W-1:0]        rem_next;
  logic signed [ske_pkg::DIFF_W-1:0] est_sum;
  logic [ske_pkg::GROW_W-1:0]        grow_sh;
  logic [ske_pkg::DATA_W-1:0]        err_sum;
  logic                              err_sat;
  logic [ske_pkg::REG_W-1:0]         err_new;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign commit   = (state == ske_pkg::ST_SUM) && (!result_valid || result_ready);
  assign div_last = (cnt == ske_pkg::CNT_W'(ske_pkg::DIV_STEPS - 1));

  assign estimate  = last_estimate;
  assign gain      = last_gain;
  assign error_now = estimate_error;

  // register read-back
  always_comb begin
    case (paddr[3:2])
      ske_pkg::REG_MEAS_ERR: prdata = {1'b0, meas_err};
      ske_pkg::REG_INIT_ERR: prdata = {1'b0, init_err};
      ske_pkg::REG_PNOISE:   prdata = {1'b0, pnoise};
      default:               prdata = '0;
    endcase
  end

  // Restoring division step: shift in the next numerator bit. The numerator is
  // error << 16 and the remainder starts at error >> 1, so only error[0] and
  // zeros remain to shift in.
  assign rem_shift = {rem, (cnt == '0) ? estimate_error[0] : 1'b0};
  assign rem_sub   = rem_shift - {1'b0, den};
  assign rem_ge    = (rem_shift >= {1'b0, den});
  assign rem_next  = rem_ge ? rem_sub[ske_pkg::DATA_W-1:0] : rem_shift[ske_pkg::DATA_W-1:0];

  // Step the estimate toward the sample; magnitude was truncated, so round toward zero.
  assign est_sum = neg ? ({last_estimate[ske_pkg::DATA_W-1], last_estimate} - $signed(change))
                       : ({last_estimate[ske_pkg::DATA_W-1], last_estimate} + $signed(change));

  // Error update with saturation at the 31-bit maximum.
  assign grow_sh = gtotal >> FRAC_BITS;
  assign err_sum = {1'b0, keep} + {1'b0, grow_sh[ske_pkg::REG_W-1:0]};
  assign err_sat = (|grow_sh[ske_pkg::GROW_W-1:ske_pkg::REG_W]) || err_sum[ske_pkg::REG_W];
  assign err_new = err_sat ? '1 : err_sum[ske_pkg::REG_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ske_pkg::ST_IDLE:  if (sample_valid) state_next = ske_pkg::ST_DEN;
      ske_pkg::ST_DEN:   state_next = ske_pkg::ST_MAG;
      ske_pkg::ST_MAG:   state_next = ske_pkg::ST_DIV;
      ske_pkg::ST_DIV:   if (div_last) state_next = ske_pkg::ST_GAIN;
      ske_pkg::ST_GAIN:  state_next = ske_pkg::ST_MEST;
      ske_pkg::ST_MEST:  state_next = ske_pkg::ST_EST;
      ske_pkg::ST_EST:   state_next = ske_pkg::ST_MKEEP;
      ske_pkg::ST_MKEEP: state_next = ske_pkg::ST_MGLO;
      ske_pkg::ST_MGLO:  state_next = ske_pkg::ST_MGHI;
      ske_pkg::ST_MGHI:  state_next = ske_pkg::ST_GACC;
      ske_pkg::ST_GACC:  state_next = ske_pkg::ST_SUM;
      ske_pkg::ST_SUM:   if (commit) state_next = ske_pkg::ST_IDLE;
      default:           state_next = ske_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake and multiplier operand select
  always_comb begin
    sample_ready = (state == ske_pkg::ST_IDLE);
    mul_a        = '0;
    mul_b        = '0;
    case (state)
      ske_pkg::ST_MEST: begin
        mul_a = gain_w;
        mul_b = mag;
      end
      ske_pkg::ST_MKEEP: begin
        mul_a = ngain;
        mul_b = {2'b00, estimate_error};
      end
      ske_pkg::ST_MGLO: begin
        mul_a = change[ske_pkg::GAIN_W-1:0];
        mul_b = {2'b00, pnoise};
      end
      ske_pkg::ST_MGHI: begin
        mul_a = {1'b0, change[ske_pkg::DIFF_W-1:ske_pkg::GAIN_W]};
        mul_b = {2'b00, pnoise};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ske_pkg::ST_IDLE;
      result_valid <= 1'b0;
      cnt          <= '0;
    end else begin
      state <= state_next;
      if (commit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (state == ske_pkg::ST_DIV) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

  // configuration registers and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      meas_err       <= ske_pkg::MEAS_ERR_RST;
      init_err       <= ske_pkg::INIT_ERR_RST;
      pnoise         <= ske_pkg::PNOISE_RST;
      last_estimate  <= '0;
      estimate_error <= ske_pkg::INIT_ERR_RST;
      last_gain      <= '0;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          ske_pkg::REG_MEAS_ERR: meas_err <= pwdata[ske_pkg::REG_W-1:0];
          ske_pkg::REG_INIT_ERR: begin
            init_err       <= pwdata[ske_pkg::REG_W-1:0];
            estimate_error <= pwdata[ske_pkg::REG_W-1:0];
          end
          ske_pkg::REG_PNOISE:   pnoise <= pwdata[ske_pkg::REG_W-1:0];
          default: ;
        endcase
      end
      if (commit) begin
        last_estimate  <= est_new;
        estimate_error <= err_new;
        last_gain      <= gain_w;
      end
    end
  end

  // datapath working registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      ske_pkg::ST_IDLE: begin
        if (sample_valid) samp <= sample;
      end
      ske_pkg::ST_DEN: begin
        den  <= {1'b0, estimate_error} + {1'b0, meas_err};
        diff <= {samp[ske_pkg::DATA_W-1], samp}
                - {last_estimate[ske_pkg::DATA_W-1], last_estimate};
      end
      ske_pkg::ST_MAG: begin
        neg  <= diff[ske_pkg::DIFF_W-1];
        mag  <= diff[ske_pkg::DIFF_W-1] ? ske_pkg::DIFF_W'(-diff) : ske_pkg::DIFF_W'(diff);
        rem  <= {2'b00, estimate_error[ske_pkg::REG_W-1:1]};
        quot <= '0;
      end
      ske_pkg::ST_DIV: begin
        rem  <= rem_next;
        quot <= {quot[ske_pkg::GAIN_W-2:0], rem_ge};
      end
      ske_pkg::ST_GAIN: begin
        // both error terms zero: gain is zero
        gain_w <= (den == '0) ? '0 : quot;
      end
      ske_pkg::ST_EST: begin
        change <= prod[ske_pkg::PROD_W-2:ske_pkg::GAIN_BITS];
        ngain  <= ske_pkg::GAIN_ONE - gain_w;
      end
      ske_pkg::ST_MKEEP: begin
        est_new <= est_sum[ske_pkg::DATA_W-1:0];
      end
      ske_pkg::ST_MGLO: begin
        keep <= prod[ske_pkg::REG_W+ske_pkg::GAIN_BITS-1:ske_pkg::GAIN_BITS];
      end
      ske_pkg::ST_MGHI: begin
        glo <= prod[47:0];
      end
      ske_pkg::ST_GACC: begin
        gtotal <= {16'b0, glo} + {prod[46:0], 17'b0};
      end
      default: ;
    endcase
  end

  // gain of a result never exceeds one
  a_gain_max: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (gain <= ske_pkg::GAIN_ONE))
    else $error("gain above one");

  // zero denominator forces a zero gain
  a_den_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ske_pkg::ST_GAIN && den == '0) |=> (gain_w == '0))
    else $error("nonzero gain on zero denominator");

  // an accepted sample blocks the input on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_ready) |=> !sample_ready)
    else $error("sample taken while busy");

  // divider count stays within the quotient width
  a_div_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == ske_pkg::ST_DIV) |-> (cnt <= ske_pkg::CNT_W'(ske_pkg::DIV_STEPS - 1)))
    else $error("divider overrun");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(estimate)))
    else $error("pending result overwritten");

endmodule
